// ===== rtl/lrc_pkg.sv =====
// Shared types, widths, outcode constants and the region function for the
// line raster collision block. Used by line_raster_collision and lrc_div.
package lrc_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int IN_W  = 16;
    localparam int CW    = 18;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int FW    = DW + 3;
    localparam int REG_W = 9;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_TOP    = 4'd4;
    localparam logic [3:0] OC_BOTTOM = 4'd8;

    localparam logic [4:0] CLIP_STEP_LIMIT = 5'd16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WALK_INIT,
        ST_PROBE,
        ST_CHECK,
        ST_OUT
    } state_t;

    function automatic logic [3:0] region(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] xmax,
                                          input logic signed [CW-1:0] ymax);
        logic [3:0] c;
        c = 4'd0;
        if (x > xmax)
        begin
            c = OC_RIGHT;
        end
        else if (x < 0)
        begin
            c = OC_LEFT;
        end
        if (y > ymax)
        begin
            c = c | OC_BOTTOM;
        end
        else if (y < 0)
        begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

endpackage

// ===== rtl/line_raster_collision.sv =====
// Top level of the line raster collision block: solid map memory, clipper and
// line walker sequencer. Depends on lrc_pkg and instantiates lrc_div.
//
// After reset the block clears its solid map one pixel a cycle and takes
// no request until every pixel is cleared. A load request gives no result. A
// test request gives one result; each Cohen-Sutherland clip step runs a
// multiply and then a division in the shared one-bit-per-cycle divider (at
// most four steps in practice, sixteen at worst), and the Bresenham walk then
// reads the solid map for each probed pixel in ST_PROBE and checks it in
// ST_CHECK. The block takes no new request until the result of the last
// test has been delivered.
module line_raster_collision #(
    parameter int MAX_WIDTH  = lrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [lrc_pkg::REG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [7:0]                       pixel_col,
    input  logic [7:0]                       pixel_row,
    input  logic [7:0]                       pixel_byte,
    input  logic signed [lrc_pkg::IN_W-1:0]  start_x,
    input  logic signed [lrc_pkg::IN_W-1:0]  start_y,
    input  logic signed [lrc_pkg::IN_W-1:0]  end_x,
    input  logic signed [lrc_pkg::IN_W-1:0]  end_y,
    input  logic signed [lrc_pkg::IN_W-1:0]  origin_x,
    input  logic signed [lrc_pkg::IN_W-1:0]  origin_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit
);

    localparam int CW    = lrc_pkg::CW;
    localparam int DW    = lrc_pkg::DW;
    localparam int PW    = lrc_pkg::PW;
    localparam int FW    = lrc_pkg::FW;
    localparam int REG_W = lrc_pkg::REG_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lrc_pkg::state_t state_reg, state_next;

    logic [REG_W-1:0] rw_reg, rw_next;
    logic [REG_W-1:0] rh_reg, rh_next;
    logic [AW:0]      clear_cnt_reg, clear_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;

    logic signed [CW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [CW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [4:0]           steps_reg, steps_next;
    logic signed [DW-1:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic signed [DW-1:0] den_reg, den_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [CW-1:0] base_reg, base_next, fixed_reg, fixed_next;
    logic                 clip_y_reg, clip_y_next, clip_b_reg, clip_b_next;
    logic [DW:0]          dmaj2_reg, dmaj2_next, dmin2_reg, dmin2_next;
    logic signed [FW-1:0] frac_reg, frac_next;
    logic                 sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic                 xmaj_reg, xmaj_next;

    logic          mem [DEPTH];
    logic          rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic                 div_start;
    logic                 div_done;
    logic signed [DW-1:0] div_q;

    logic signed [CW-1:0] w_eff, h_eff, xmax, ymax;
    logic [3:0]           ca, cb, code;
    logic signed [DW-1:0] dx, dy, adx, ady;
    logic signed [DW-1:0] new_coord;
    logic                 frac_ge, in_rect, at_end;
    logic signed [CW-1:0] ax_step, ay_step;

    lrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (rw_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (CW'(rw_reg) > CW'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(rw_reg);
        end
        if (rh_reg == '0)
        begin
            h_eff = CW'(1);
        end
        else if (CW'(rh_reg) > CW'(MAX_HEIGHT))
        begin
            h_eff = CW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = CW'(rh_reg);
        end
        xmax = w_eff - CW'(1);
        ymax = h_eff - CW'(1);
    end

    always_comb
    begin
        ca   = lrc_pkg::region(ax_reg, ay_reg, xmax, ymax);
        cb   = lrc_pkg::region(bx_reg, by_reg, xmax, ymax);
        code = (ca != 4'd0) ? ca : cb;

        dx  = DW'(bx_reg) - DW'(ax_reg);
        dy  = DW'(by_reg) - DW'(ay_reg);
        adx = dx[DW-1] ? -dx : dx;
        ady = dy[DW-1] ? -dy : dy;

        new_coord = DW'(base_reg) + div_q;

        frac_ge = !frac_reg[FW-1];
        in_rect = !ax_reg[CW-1] && !ay_reg[CW-1] && (ax_reg < w_eff) && (ay_reg < h_eff);
        at_end  = xmaj_reg ? (ax_reg == bx_reg) : (ay_reg == by_reg);
        ax_step = sx_neg_reg ? ax_reg - CW'(1) : ax_reg + CW'(1);
        ay_step = sy_neg_reg ? ay_reg - CW'(1) : ay_reg + CW'(1);

        mem_raddr = AW'(AW'($unsigned(ay_reg)) * AW'(MAX_WIDTH) + AW'($unsigned(ax_reg)));
    end

    always_comb
    begin
        state_next     = state_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        clear_cnt_next = clear_cnt_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        steps_next     = steps_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        fixed_next     = fixed_reg;
        clip_y_next    = clip_y_reg;
        clip_b_next    = clip_b_reg;
        dmaj2_next     = dmaj2_reg;
        dmin2_next     = dmin2_reg;
        frac_next      = frac_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        xmaj_next      = xmaj_reg;
        in_ready       = 1'b0;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = AW'(AW'(pixel_row) * AW'(MAX_WIDTH) + AW'(pixel_col));
        mem_wdata      = (pixel_byte != 8'd0);

        if (cfg_we)
        begin
            case (cfg_index)
                lrc_pkg::CFG_WIDTH:  rw_next = cfg_data;
                lrc_pkg::CFG_HEIGHT: rh_next = cfg_data;
                default:             rw_next = rw_reg;
            endcase
        end

        case (state_reg)
            lrc_pkg::ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = clear_cnt_reg[AW-1:0];
                mem_wdata      = 1'b0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = lrc_pkg::ST_IDLE;
                end
            end
            lrc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == lrc_pkg::CMD_LOAD)
                    begin
                        mem_we = (32'(pixel_col) < MAX_WIDTH) && (32'(pixel_row) < MAX_HEIGHT);
                    end
                    else
                    begin
                        ax_next    = CW'(start_x) - CW'(origin_x);
                        ay_next    = CW'(start_y) - CW'(origin_y);
                        bx_next    = CW'(end_x) - CW'(origin_x);
                        by_next    = CW'(end_y) - CW'(origin_y);
                        steps_next = '0;
                        state_next = lrc_pkg::ST_CLIP;
                    end
                end
            end
            lrc_pkg::ST_CLIP:
            begin
                clip_b_next = (ca == 4'd0);
                steps_next  = steps_reg + 1'b1;
                if ((ca == 4'd0) && (cb == 4'd0))
                begin
                    state_next = lrc_pkg::ST_WALK_INIT;
                end
                else if (((ca & cb) != 4'd0) || (steps_reg == lrc_pkg::CLIP_STEP_LIMIT))
                begin
                    hit_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = lrc_pkg::ST_OUT;
                end
                else if ((code & (lrc_pkg::OC_BOTTOM | lrc_pkg::OC_TOP)) != 4'd0)
                begin
                    fixed_next  = ((code & lrc_pkg::OC_BOTTOM) != 4'd0) ? ymax : '0;
                    mul_a_next  = dx;
                    mul_b_next  = DW'(fixed_next) - DW'(ay_reg);
                    den_next    = dy;
                    base_next   = ax_reg;
                    clip_y_next = 1'b1;
                    if (by_reg == ay_reg)
                    begin
                        hit_next       = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = lrc_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = lrc_pkg::ST_MUL;
                    end
                end
                else
                begin
                    fixed_next  = ((code & lrc_pkg::OC_RIGHT) != 4'd0) ? xmax : '0;
                    mul_a_next  = dy;
                    mul_b_next  = DW'(fixed_next) - DW'(ax_reg);
                    den_next    = dx;
                    base_next   = ay_reg;
                    clip_y_next = 1'b0;
                    if (bx_reg == ax_reg)
                    begin
                        hit_next       = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = lrc_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = lrc_pkg::ST_MUL;
                    end
                end
            end
            lrc_pkg::ST_MUL:
            begin
                prod_next  = PW'(mul_a_reg) * PW'(mul_b_reg);
                state_next = lrc_pkg::ST_DIV_GO;
            end
            lrc_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = lrc_pkg::ST_DIV_WAIT;
            end
            lrc_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lrc_pkg::ST_CLIP;
                    if (clip_b_reg)
                    begin
                        bx_next = clip_y_reg ? CW'(new_coord) : fixed_reg;
                        by_next = clip_y_reg ? fixed_reg : CW'(new_coord);
                    end
                    else
                    begin
                        ax_next = clip_y_reg ? CW'(new_coord) : fixed_reg;
                        ay_next = clip_y_reg ? fixed_reg : CW'(new_coord);
                    end
                end
            end
            lrc_pkg::ST_WALK_INIT:
            begin
                sx_neg_next = dx[DW-1];
                sy_neg_next = dy[DW-1];
                xmaj_next   = (adx > ady);
                if (adx > ady)
                begin
                    dmaj2_next = {adx[DW-1:0], 1'b0};
                    dmin2_next = {ady[DW-1:0], 1'b0};
                    frac_next  = $signed(FW'({ady[DW-1:0], 1'b0})) - $signed(FW'(adx[DW-1:0]));
                end
                else
                begin
                    dmaj2_next = {ady[DW-1:0], 1'b0};
                    dmin2_next = {adx[DW-1:0], 1'b0};
                    frac_next  = $signed(FW'({adx[DW-1:0], 1'b0})) - $signed(FW'(ady[DW-1:0]));
                end
                state_next = lrc_pkg::ST_PROBE;
            end
            lrc_pkg::ST_PROBE:
            begin
                state_next = lrc_pkg::ST_CHECK;
            end
            lrc_pkg::ST_CHECK:
            begin
                if (in_rect && rd_data_reg)
                begin
                    hit_next       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lrc_pkg::ST_OUT;
                end
                else if (at_end)
                begin
                    hit_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = lrc_pkg::ST_OUT;
                end
                else
                begin
                    frac_next = frac_reg + $signed(FW'(dmin2_reg))
                              - (frac_ge ? $signed(FW'(dmaj2_reg)) : $signed(FW'(0)));
                    if (xmaj_reg)
                    begin
                        ax_next = ax_step;
                        ay_next = frac_ge ? ay_step : ay_reg;
                    end
                    else
                    begin
                        ay_next = ay_step;
                        ax_next = frac_ge ? ax_step : ax_reg;
                    end
                    state_next = lrc_pkg::ST_PROBE;
                end
            end
            lrc_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = lrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrc_pkg::ST_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        hit       = hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrc_pkg::ST_CLEAR;
            rw_reg        <= REG_W'(256);
            rh_reg        <= REG_W'(256);
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rw_reg        <= rw_next;
            rh_reg        <= rh_next;
            clear_cnt_reg <= clear_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        steps_reg  <= steps_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        den_reg    <= den_next;
        prod_reg   <= prod_next;
        base_reg   <= base_next;
        fixed_reg  <= fixed_next;
        clip_y_reg <= clip_y_next;
        clip_b_reg <= clip_b_next;
        dmaj2_reg  <= dmaj2_next;
        dmin2_reg  <= dmin2_next;
        frac_reg   <= frac_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        xmaj_reg   <= xmaj_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ===== rtl/lrc_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on lrc_pkg for the product and delta widths.
module lrc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [lrc_pkg::PW-1:0]  dividend,
    input  logic signed [lrc_pkg::DW-1:0]  divisor,
    output logic                           done,
    output logic signed [lrc_pkg::DW-1:0]  quotient
);

    localparam int PW = lrc_pkg::PW;
    localparam int DW = lrc_pkg::DW;
    localparam int NB = PW - 1;
    localparam int CNTW = $clog2(NB);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NB-1:0]   num_reg, num_next;
    logic [DW-2:0]   rem_reg, rem_next;
    logic [DW-2:0]   den_reg, den_next;
    logic            neg_reg, neg_next;

    logic signed [PW-1:0] dividend_abs;
    logic signed [DW-1:0] divisor_abs;
    logic [DW-1:0]        trial;
    logic                 qbit;
    logic [DW-1:0]        qmag;

    always_comb
    begin
        dividend_abs = dividend[PW-1] ? -dividend : dividend;
        divisor_abs  = divisor[DW-1] ? -divisor : divisor;
        trial        = {rem_reg, num_reg[NB-1]};
        qbit         = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NB - 1);
            num_next  = dividend_abs[NB-1:0];
            rem_next  = '0;
            den_next  = divisor_abs[DW-2:0];
            neg_next  = dividend[PW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? (DW-1)'(trial - {1'b0, den_reg}) : trial[DW-2:0];
            num_next = {num_reg[NB-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        qmag     = num_reg[DW-1:0];
        quotient = neg_reg ? -$signed(qmag) : $signed(qmag);
        done     = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for line_raster_collision: loads pixels, tests line
// segments and compares each hit result with an in-bench clip-and-walk model.
// Depends on lrc_pkg and the line_raster_collision RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_W        = 256;
    localparam int MAP_H        = 256;
    localparam longint CYCLE_CAP = 20_000_000;

    typedef struct {
        logic               command;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [7:0]         pbyte;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } request_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [lrc_pkg::REG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
    logic [7:0] pixel_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic out_valid;
    logic out_ready;
    logic hit;

    bit          solid_copy [0:MAP_W*MAP_H-1];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    bit          hit_queue[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          tests_sent;
    int          loads_sent;
    int          hits_seen;
    int          results_seen;
    longint      cycles = 0;

    line_raster_collision u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .pixel_col(pixel_col), .pixel_row(pixel_row),
        .pixel_byte(pixel_byte), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y), .origin_x(origin_x), .origin_y(origin_y),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("line_raster_collision verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (hit_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0b with nothing pending", hit);
            end
            else
            begin
                want = hit_queue.pop_front();
                if (hit) hits_seen++;
                if (hit !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected %0b, got %0b", want, hit);
                end
            end
        end
    end

    function automatic logic [3:0] zone_code(longint x, longint y, longint xmax,
                                             longint ymax);
        logic [3:0] c;
        c = 4'd0;
        if (x > xmax)
            c = lrc_pkg::OC_RIGHT;
        else if (x < 0)
            c = lrc_pkg::OC_LEFT;
        if (y > ymax)
            c = c | lrc_pkg::OC_BOTTOM;
        else if (y < 0)
            c = c | lrc_pkg::OC_TOP;
        return c;
    endfunction

    function automatic bit pixel_solid(longint x, longint y, longint w, longint h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return solid_copy[y * MAP_W + x];
    endfunction

    function automatic bit segment_hits(longint ax, longint ay, longint bx, longint by);
        longint w, h, xmax, ymax, nx, ny, dx, dy, stx, sty, frac;
        logic [3:0] ca, cb, c;
        int steps;
        w = (width_reg == 0) ? 1 : ((width_reg > MAP_W) ? MAP_W : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAP_H) ? MAP_H : height_reg);
        xmax = w - 1;
        ymax = h - 1;
        ca = zone_code(ax, ay, xmax, ymax);
        cb = zone_code(bx, by, xmax, ymax);
        steps = 0;
        while (ca != 0 || cb != 0)
        begin
            if ((ca & cb) != 0) return 1'b0;
            steps++;
            if (steps > lrc_pkg::CLIP_STEP_LIMIT) return 1'b0;
            c = (ca != 0) ? ca : cb;
            if ((c & (lrc_pkg::OC_BOTTOM | lrc_pkg::OC_TOP)) != 0)
            begin
                if (by == ay) return 1'b0;
                ny = ((c & lrc_pkg::OC_BOTTOM) != 0) ? ymax : 0;
                nx = ax + ((bx - ax) * (ny - ay)) / (by - ay);
            end
            else
            begin
                if (bx == ax) return 1'b0;
                nx = ((c & lrc_pkg::OC_RIGHT) != 0) ? xmax : 0;
                ny = ay + ((by - ay) * (nx - ax)) / (bx - ax);
            end
            if (c == ca)
            begin
                ax = nx;
                ay = ny;
                ca = zone_code(ax, ay, xmax, ymax);
            end
            else
            begin
                bx = nx;
                by = ny;
                cb = zone_code(bx, by, xmax, ymax);
            end
        end
        dx = bx - ax;
        dy = by - ay;
        stx = 1;
        sty = 1;
        if (dx < 0)
        begin
            dx = -dx;
            stx = -1;
        end
        if (dy < 0)
        begin
            dy = -dy;
            sty = -1;
        end
        dx = dx * 2;
        dy = dy * 2;
        if (pixel_solid(ax, ay, w, h)) return 1'b1;
        if (dx > dy)
        begin
            frac = dy - dx / 2;
            while (ax != bx)
            begin
                if (frac >= 0)
                begin
                    ay += sty;
                    frac -= dx;
                end
                ax += stx;
                frac += dy;
                if (pixel_solid(ax, ay, w, h)) return 1'b1;
            end
        end
        else
        begin
            frac = dx - dy / 2;
            while (ay != by)
            begin
                if (frac >= 0)
                begin
                    ax += stx;
                    frac -= dy;
                end
                ay += sty;
                frac += dx;
                if (pixel_solid(ax, ay, w, h)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_request(request_t r);
        longint ox, oy;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= r.command;
        pixel_col  <= r.col;
        pixel_row  <= r.row;
        pixel_byte <= r.pbyte;
        start_x    <= r.sx;
        start_y    <= r.sy;
        end_x      <= r.ex;
        end_y      <= r.ey;
        origin_x   <= r.ox;
        origin_y   <= r.oy;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        if (r.command == lrc_pkg::CMD_LOAD)
        begin
            solid_copy[r.row * MAP_W + r.col] = (r.pbyte != 0);
            loads_sent++;
        end
        else
        begin
            ox = r.ox;
            oy = r.oy;
            hit_queue.push_back(segment_hits(longint'(r.sx) - ox, longint'(r.sy) - oy,
                                             longint'(r.ex) - ox, longint'(r.ey) - oy));
            tests_sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [8:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lrc_pkg::CFG_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    task automatic load_pixel(int c, int rw, int b);
        request_t r;
        r = '{default: '0};
        r.command = lrc_pkg::CMD_LOAD;
        r.col = 8'(c);
        r.row = 8'(rw);
        r.pbyte = 8'(b);
        send_request(r);
    endtask

    task automatic test_line(int x0, int y0, int x1, int y1, int ox, int oy);
        request_t r;
        r = '{default: '0};
        r.command = lrc_pkg::CMD_TEST;
        r.sx = 16'(x0 + ox);
        r.sy = 16'(y0 + oy);
        r.ex = 16'(x1 + ox);
        r.ey = 16'(y1 + oy);
        r.ox = 16'(ox);
        r.oy = 16'(oy);
        send_request(r);
    endtask

    task automatic test_directed();
        load_pixel(0, 0, 8'hFF);
        load_pixel(255, 255, 8'h01);
        load_pixel(100, 37, 8'h80);
        load_pixel(5, 200, 8'h00);
        test_line(-10, 0, 300, 0, 0, 0);
        test_line(255, -50, 255, 400, -32768, 32767);
        test_line(0, 255, 255, 0, 32767, -32768);
        test_line(90, 30, 110, 44, 1234, -999);
        test_line(-5, -5, -1, -300, 0, 0);
        test_line(100, 37, 100, 37, 0, 0);
        test_line(40, 40, 40, 40, 0, 0);
        begin
            request_t r;
            r = '{command: lrc_pkg::CMD_TEST, col: 8'hFF, row: 8'hFF, pbyte: 8'hFF,
                  sx: 16'sh8000, sy: 16'sh7FFF, ex: 16'sh7FFF, ey: 16'sh8000,
                  ox: 16'sh0000, oy: 16'sh0000};
            send_request(r);
            r.sx = 16'sh7FFF;
            r.sy = 16'sh7FFF;
            r.ex = 16'sh8000;
            r.ey = 16'sh8000;
            r.ox = 16'sh7FFF;
            r.oy = 16'sh7FFF;
            send_request(r);
        end
        load_pixel(0, 0, 8'h00);
        test_line(-3, 0, 2, 0, 0, 0);
        test_line(300, 300, 250, 260, 0, 0);
    endtask

    task automatic test_register_extremes();
        write_register(lrc_pkg::CFG_WIDTH, 9'd0);
        write_register(lrc_pkg::CFG_HEIGHT, 9'd0);
        load_pixel(0, 0, 8'h11);
        test_line(-4, -4, 4, 4, 0, 0);
        test_line(0, 0, 0, 0, 0, 0);
        write_register(lrc_pkg::CFG_WIDTH, 9'h1FF);
        write_register(lrc_pkg::CFG_HEIGHT, 9'd300);
        test_line(-10, 255, 400, 255, 0, 0);
        write_register(lrc_pkg::CFG_WIDTH, 9'd1);
        write_register(lrc_pkg::CFG_HEIGHT, 9'd256);
        test_line(0, -20, 0, 400, 0, 0);
        test_line(-1, 5, 3, 255, 0, 0);
    endtask

    function automatic int pick_size();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return $urandom_range(257, 511);
            3: return 256;
            4: return $urandom_range(2, 8);
            default: return $urandom_range(9, 96);
        endcase
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        request_t r;
        int w, h, ox, oy;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        w = pick_size();
        h = pick_size();
        write_register(lrc_pkg::CFG_WIDTH, 9'(w));
        write_register(lrc_pkg::CFG_HEIGHT, 9'(h));
        w = (w == 0) ? 1 : ((w > MAP_W) ? MAP_W : w);
        h = (h == 0) ? 1 : ((h > MAP_H) ? MAP_H : h);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && idle == 0)
                drain_results();
            r.col   = 8'($urandom_range(99) < 80 ? $urandom_range(w - 1)
                                                 : $urandom_range(255));
            r.row   = 8'($urandom_range(99) < 80 ? $urandom_range(h - 1)
                                                 : $urandom_range(255));
            r.pbyte = 8'($urandom_range(99) < 35 ? 0 : $urandom_range(255));
            ox = $urandom_range(99) < 30 ? $urandom_range(65535) : $urandom_range(200) - 100;
            oy = $urandom_range(99) < 30 ? $urandom_range(65535) : $urandom_range(200) - 100;
            r.ox = 16'(ox);
            r.oy = 16'(oy);
            if ($urandom_range(99) < 10)
            begin
                r.sx = 16'($urandom_range(65535));
                r.sy = 16'($urandom_range(65535));
                r.ex = 16'($urandom_range(65535));
                r.ey = 16'($urandom_range(65535));
            end
            else
            begin
                r.sx = 16'(ox + int'($urandom_range(w + 40)) - 20);
                r.sy = 16'(oy + int'($urandom_range(h + 40)) - 20);
                r.ex = 16'(ox + int'($urandom_range(w + 40)) - 20);
                r.ey = 16'(oy + int'($urandom_range(h + 40)) - 20);
            end
            r.command = ($urandom_range(99) < 40) ? lrc_pkg::CMD_LOAD : lrc_pkg::CMD_TEST;
            send_request(r);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= 1'b0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        command    <= lrc_pkg::CMD_LOAD;
        pixel_col  <= '0;
        pixel_row  <= '0;
        pixel_byte <= '0;
        start_x    <= '0;
        start_y    <= '0;
        end_x      <= '0;
        end_y      <= '0;
        origin_x   <= '0;
        origin_y   <= '0;
        mismatches = 0;
        tests_sent = 0;
        loads_sent = 0;
        hits_seen = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        foreach (solid_copy[i])
            solid_copy[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        test_directed();
        test_register_extremes();
        for (int p = 0; p < 16; p++)
        begin
            case (p % 4)
                0: random_phase(100, 0, 0);
                1: random_phase(100, 50, 0);
                2: random_phase(100, 0, 50);
                default: random_phase(100, 24, 24);
            endcase
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (1200) @(posedge clk);
        $display("Covered %0d pixel loads and %0d segment tests (%0d hits) over several",
                 loads_sent, tests_sent, hits_seen);
        $display("raster sizes, including clamped and zero sizes, with idle and stall phases.");
        if (mismatches == 0 && hit_queue.size() == 0)
            $display("line_raster_collision verification clean");
        else
            $display("line_raster_collision verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/lrc_pkg.sv
rtl/lrc_div.sv
rtl/line_raster_collision.sv
dv/tb.sv
